@@ src/unix_seconds_to_civil_date_core_assert.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef UNIX_SECONDS_TO_CIVIL_DATE_CORE_ASSERT_SVH
`define UNIX_SECONDS_TO_CIVIL_DATE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define U2CD_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("u2cd assertion failed");

// next-cycle implication, disabled while reset is low
`define U2CD_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("u2cd assertion failed");

`endif

@@ src/u2cd_pkg.sv @@
// types, constants and microcode rom for the unix seconds to civil date core
// no dependencies
package u2cd_pkg;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,
    OP_SEC,
    OP_MIN,
    OP_HR,
    OP_YEST,
    OP_ACC365,
    OP_C100,
    OP_C400,
    OP_TSUB,
    OP_YSTEP,
    OP_MONTH
  } op_e;

  typedef enum logic [2:0] {
    DIV_60,
    DIV_24,
    DIV_366,
    DIV_100,
    DIV_400
  } div_e;

  typedef enum logic {
    SRC_T,
    SRC_P
  } src_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_FITS,
    JMP_END
  } jmp_e;

  localparam int UcLen = 17;
  localparam int StepW = $clog2(UcLen);

  typedef logic [StepW-1:0] step_t;

  localparam step_t STEP_YEAR = step_t'(14);

  typedef struct packed {
    op_e  op;
    div_e div;
    src_e src;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    jmp_e  jmp;
    step_t addr;
  } uword_t;

  localparam logic [31:0] RECIP_60  = 32'((64'd1 << 32) / 64'd60);
  localparam logic [31:0] RECIP_24  = 32'((64'd1 << 32) / 64'd24);
  localparam logic [31:0] RECIP_366 = 32'((64'd1 << 32) / 64'd366);
  localparam logic [31:0] RECIP_100 = 32'((64'd1 << 32) / 64'd100);
  localparam logic [31:0] RECIP_400 = 32'((64'd1 << 32) / 64'd400);

  localparam logic [31:0] EPOCH_DAYS = 32'd719162;
  localparam logic [11:0] YEAR_BASE  = 12'd1970;

  function automatic logic [8:0] div_const(div_e d);
    logic [8:0] c;
    unique case (d)
      DIV_60:  c = 9'd60;
      DIV_24:  c = 9'd24;
      DIV_366: c = 9'd366;
      DIV_100: c = 9'd100;
      DIV_400: c = 9'd400;
      default: c = 9'd60;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] div_recip(div_e d);
    logic [31:0] r;
    unique case (d)
      DIV_60:  r = RECIP_60;
      DIV_24:  r = RECIP_24;
      DIV_366: r = RECIP_366;
      DIV_100: r = RECIP_100;
      DIV_400: r = RECIP_400;
      default: r = RECIP_60;
    endcase
    return r;
  endfunction

  // days before the start of month m (m = 12 gives the year length)
  function automatic logic [8:0] cum_days(logic lp, logic [3:0] m);
    logic [8:0] n;
    unique case (m)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd59;
      4'd3:    n = 9'd90;
      4'd4:    n = 9'd120;
      4'd5:    n = 9'd151;
      4'd6:    n = 9'd181;
      4'd7:    n = 9'd212;
      4'd8:    n = 9'd243;
      4'd9:    n = 9'd273;
      4'd10:   n = 9'd304;
      4'd11:   n = 9'd334;
      default: n = 9'd365;
    endcase
    if (lp && m >= 4'd2) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

  function automatic uword_t mk(op_e op, div_e d, src_e s, jmp_e j, step_t a);
    uword_t w;
    w.ctrl.op  = op;
    w.ctrl.div = d;
    w.ctrl.src = s;
    w.jmp      = j;
    w.addr     = a;
    return w;
  endfunction

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    unique case (s)
      step_t'(0):  w = mk(OP_MUL,    DIV_60,  SRC_T, JMP_NEXT, '0);
      step_t'(1):  w = mk(OP_SEC,    DIV_60,  SRC_T, JMP_NEXT, '0);
      step_t'(2):  w = mk(OP_MUL,    DIV_60,  SRC_T, JMP_NEXT, '0);
      step_t'(3):  w = mk(OP_MIN,    DIV_60,  SRC_T, JMP_NEXT, '0);
      step_t'(4):  w = mk(OP_MUL,    DIV_24,  SRC_T, JMP_NEXT, '0);
      step_t'(5):  w = mk(OP_HR,     DIV_24,  SRC_T, JMP_NEXT, '0);
      step_t'(6):  w = mk(OP_MUL,    DIV_366, SRC_T, JMP_NEXT, '0);
      step_t'(7):  w = mk(OP_YEST,   DIV_366, SRC_T, JMP_NEXT, '0);
      step_t'(8):  w = mk(OP_ACC365, DIV_100, SRC_P, JMP_NEXT, '0);
      step_t'(9):  w = mk(OP_MUL,    DIV_100, SRC_P, JMP_NEXT, '0);
      step_t'(10): w = mk(OP_C100,   DIV_100, SRC_P, JMP_NEXT, '0);
      step_t'(11): w = mk(OP_MUL,    DIV_400, SRC_P, JMP_NEXT, '0);
      step_t'(12): w = mk(OP_C400,   DIV_400, SRC_P, JMP_NEXT, '0);
      step_t'(13): w = mk(OP_TSUB,   DIV_60,  SRC_T, JMP_NEXT, '0);
      STEP_YEAR:   w = mk(OP_YSTEP,  DIV_60,  SRC_T, JMP_FITS, STEP_YEAR);
      step_t'(15): w = mk(OP_MONTH,  DIV_60,  SRC_T, JMP_NEXT, '0);
      default:     w = mk(OP_NOP,    DIV_60,  SRC_T, JMP_END,  '0);
    endcase
    return w;
  endfunction

endpackage

@@ src/unix_seconds_to_civil_date_core.sv @@
// one transaction at a time: a new one is accepted only once the previous result is loaded,
// at the end of the 17-step microcode program and its year stepping loop; the end step
// waits while the output register is full and stalled
// reset: async active low, clears sequencer and output valid; no state carried between items
// top level of the unix seconds to civil date core: sequencer, rom and output register
// depends on u2cd_pkg and u2cd_datapath
module unix_seconds_to_civil_date_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] epoch_seconds_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_of_minute_o
);
  import u2cd_pkg::*;

  logic        busy_q;
  step_t       step_q;
  logic        out_valid_q;
  uword_t      uw;
  ctrl_t       ctrl;
  logic        accept;
  logic        slot_free;
  logic        load_out;
  logic        fits;

  logic [11:0] dp_year;
  logic [3:0]  dp_month;
  logic [4:0]  dp_day;
  logic [4:0]  dp_hour;
  logic [5:0]  dp_minute;
  logic [5:0]  dp_second;

  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  assign uw        = ucode_rom(step_q);
  assign accept    = in_valid_i && !busy_q;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign load_out  = busy_q && (uw.jmp == JMP_END) && slot_free;

  always_comb begin
    ctrl = uw.ctrl;
    if (!busy_q) begin
      ctrl.op = OP_NOP;
    end
  end

  u2cd_datapath u_dp (
    .clk_i           (clk_i),
    .ctrl_i          (ctrl),
    .load_i          (accept),
    .epoch_seconds_i (epoch_seconds_i),
    .fits_o          (fits),
    .year_o          (dp_year),
    .month_o         (dp_month),
    .day_o           (dp_day),
    .hour_o          (dp_hour),
    .minute_o        (dp_minute),
    .second_o        (dp_second)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        unique case (uw.jmp)
          JMP_NEXT: step_q <= step_q + step_t'(1);
          JMP_FITS: step_q <= fits ? uw.addr : step_q + step_t'(1);
          JMP_END: begin
            if (slot_free) begin
              busy_q <= 1'b0;
            end
          end
          default: busy_q <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      year_q   <= dp_year;
      month_q  <= dp_month;
      day_q    <= dp_day;
      hour_q   <= dp_hour;
      minute_q <= dp_minute;
      second_q <= dp_second;
    end
  end

  assign in_stall_o         = busy_q;
  assign out_valid_o        = out_valid_q;
  assign year_o             = year_q;
  assign month_o            = month_q;
  assign day_of_month_o     = day_q;
  assign hour_o             = hour_q;
  assign minute_o           = minute_q;
  assign second_of_minute_o = second_q;

endmodule

@@ src/u2cd_datapath.sv @@
// datapath of the civil date core: reciprocal divider, year and month logic
// depends on u2cd_pkg
module u2cd_datapath (
  input  logic           clk_i,
  input  u2cd_pkg::ctrl_t ctrl_i,
  input  logic           load_i,
  input  logic [31:0]    epoch_seconds_i,
  output logic           fits_o,
  output logic [11:0]    year_o,
  output logic [3:0]     month_o,
  output logic [4:0]     day_o,
  output logic [4:0]     hour_o,
  output logic [5:0]     minute_o,
  output logic [5:0]     second_o
);
  import u2cd_pkg::*;

  logic [31:0] t_q;
  logic [11:0] p_q;
  logic [20:0] acc_q;
  logic [63:0] prod_q;
  logic [11:0] year_q;
  logic [6:0]  c100_q;
  logic [8:0]  c400_q;
  logic [5:0]  sec_q;
  logic [5:0]  min_q;
  logic [4:0]  hr_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;

  logic [31:0] src_v;
  logic [8:0]  cval;
  logic [31:0] q_est;
  logic [40:0] qc;
  logic [31:0] r_est;
  logic        fix;
  logic [31:0] quo;
  logic [8:0]  rem;
  logic        leap;
  logic [8:0]  ylen;
  logic [8:0]  day_idx;
  logic [3:0]  mon_d;
  logic [8:0]  base;
  logic        found;

  assign src_v = (ctrl_i.src == SRC_P) ? 32'(p_q) : t_q;
  assign cval  = div_const(ctrl_i.div);
  assign q_est = prod_q[63:32];
  assign qc    = 41'(q_est) * 41'(cval);
  assign r_est = src_v - qc[31:0];
  assign fix   = (r_est >= 32'(cval));
  assign quo   = q_est + 32'(fix);
  assign rem   = fix ? 9'(r_est - 32'(cval)) : r_est[8:0];

  assign leap   = (year_q[1:0] == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
  assign ylen   = leap ? 9'd366 : 9'd365;
  assign fits_o = (t_q >= 32'(ylen));

  assign day_idx = t_q[8:0];

  always_comb begin
    mon_d = 4'd12;
    base  = cum_days(leap, 4'd11);
    found = 1'b0;
    for (int m = 1; m <= 12; m++) begin
      if (!found && day_idx < cum_days(leap, 4'(m))) begin
        mon_d = 4'(m);
        base  = cum_days(leap, 4'(m - 1));
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      t_q <= epoch_seconds_i;
    end
    unique case (ctrl_i.op)
      OP_MUL: begin
        prod_q <= 64'(src_v) * 64'(div_recip(ctrl_i.div));
      end
      OP_SEC: begin
        sec_q <= rem[5:0];
        t_q   <= quo;
      end
      OP_MIN: begin
        min_q <= rem[5:0];
        t_q   <= quo;
      end
      OP_HR: begin
        hr_q <= rem[4:0];
        t_q  <= quo;
      end
      OP_YEST: begin
        year_q <= YEAR_BASE + quo[11:0];
        p_q    <= YEAR_BASE - 12'd1 + quo[11:0];
      end
      OP_ACC365: begin
        acc_q <= 21'(p_q) * 21'd365 + 21'(p_q[11:2]);
      end
      OP_C100: begin
        acc_q  <= acc_q - quo[20:0];
        c100_q <= (rem == 9'd99) ? 7'd0 : 7'(rem + 9'd1);
      end
      OP_C400: begin
        acc_q  <= acc_q + quo[20:0];
        c400_q <= (rem == 9'd399) ? 9'd0 : rem + 9'd1;
      end
      OP_TSUB: begin
        t_q <= t_q + EPOCH_DAYS - 32'(acc_q);
      end
      OP_YSTEP: begin
        if (fits_o) begin
          t_q    <= t_q - 32'(ylen);
          year_q <= year_q + 12'd1;
          c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
          c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
        end
      end
      OP_MONTH: begin
        month_q <= mon_d;
        day_q   <= 5'(day_idx - base + 9'd1);
      end
      default: begin
      end
    endcase
  end

  assign year_o   = year_q;
  assign month_o  = month_q;
  assign day_o    = day_q;
  assign hour_o   = hr_q;
  assign minute_o = min_q;
  assign second_o = sec_q;

endmodule

@@ src/u2cd_checker.sv @@
// port-level checker for the unix seconds to civil date core, with its bind
// depends on unix_seconds_to_civil_date_core_assert.svh
`include "unix_seconds_to_civil_date_core_assert.svh"

module u2cd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] year_o,
  input logic [3:0]  month_o,
  input logic [4:0]  day_of_month_o,
  input logic [4:0]  hour_o,
  input logic [5:0]  minute_o,
  input logic [5:0]  second_of_minute_o
);

  logic in_txn;
  logic out_hold;
  logic out_range;

  assign in_txn   = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;
  assign out_range = (year_o >= 12'd1970) && (year_o <= 12'd2106) &&
                     (month_o >= 4'd1) && (month_o <= 4'd12) &&
                     (day_of_month_o >= 5'd1) && (hour_o <= 5'd23) &&
                     (minute_o <= 6'd59) && (second_of_minute_o <= 6'd59);

  // one transaction in flight
  `U2CD_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_txn, in_stall_o)

  // a new result appears only as the sequencer frees up
  `U2CD_ASSERT_IMP(a_rise_frees_in, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

  `U2CD_ASSERT_IMP(a_out_range, clk_i, rst_ni, out_valid_o, out_range)

  `U2CD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_hold,
                   out_valid_o && $stable(year_o) && $stable(month_o) &&
                   $stable(day_of_month_o) && $stable(hour_o) &&
                   $stable(minute_o) && $stable(second_of_minute_o))

endmodule

bind unix_seconds_to_civil_date_core u2cd_checker u_chk (.*);
